[rtl/bbtb_pkg.sv]
`timescale 1ns / 1ps
package bbtb_pkg;

    // Payload of one input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
        logic [7:0] channel;
    } t_in_item;

    // Payload of one result transaction.
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  status;
        logic [8:0]  entry_index;
        logic [47:0] bssid;
        logic        privacy;
        logic [7:0]  net_channel;
        logic [5:0]  ssid_length;
        logic [7:0]  ssid_byte;
        logic [9:0]  network_count;
        logic        last_result;
    } t_out_item;

    // Status codes.
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_KNOWN     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_WRONGTYPE = 3'd4;

    localparam logic       KIND_SUMMARY = 1'b0;
    localparam logic       KIND_SSID    = 1'b1;

    // Frame layout constants.
    localparam logic [7:0]  FC_BEACON    = 8'h80;
    localparam logic [7:0]  FC_PROBERESP = 8'h50;
    localparam logic [7:0]  CAP_PRIVACY  = 8'h10;
    localparam logic [11:0] MIN_LEN      = 12'd38;
    localparam logic [11:0] IE_START     = 12'd36;
    localparam logic [11:0] POS_MAX      = 12'd4095;
    localparam logic [11:0] BSSID_FIRST  = 12'd16;
    localparam logic [11:0] BSSID_LAST   = 12'd21;
    localparam logic [11:0] CAP_POS      = 12'd34;
    localparam logic [7:0]  EID_SSID     = 8'd0;

    // Element walker phases.
    localparam logic [1:0] PH_ID  = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // SSID tracking states.
    localparam logic [1:0] SS_NONE = 2'd0;
    localparam logic [1:0] SS_COLL = 2'd1;
    localparam logic [1:0] SS_KEPT = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic parse;     // consume the input byte
        logic clear;     // clear per-frame state
        logic cmp_start; // begin a search
        logic cmp_step;  // advance search pointer
        logic write_new; // store the captured BSSID
        logic load_sum;  // latch summary fields
        logic out_load;  // load output register
        logic out_kind;  // kind of the loaded result
        logic out_last;  // last flag of the loaded result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic short_frame;
        logic type_bad;
        logic scan_done;  // every filled slot compared
        logic hit;        // compared slot matched
        logic room;       // table not full
        logic ssid_zero;  // kept SSID is empty
        logic ssid_end;   // current SSID byte is the final one
    } t_sts;

endpackage

[rtl/bbtb_datapath.sv]
`timescale 1ns / 1ps
module bbtb_datapath #(
    parameter int TABLE_DEPTH = 512,
    parameter int SSID_MAX    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bbtb_pkg::t_in_item   i_item,
    input  bbtb_pkg::t_cmd       i_cmd,
    output bbtb_pkg::t_sts       o_sts,
    output bbtb_pkg::t_out_item  o_item
);
    import bbtb_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (SSID_MAX > 1) ? $clog2(SSID_MAX) : 1;

    // Per-frame parse state.
    logic [11:0] r_pos;
    logic        r_type_ok;
    logic [47:0] r_bssid;
    logic        r_priv;
    logic [1:0]  r_phase;
    logic [7:0]  r_eid;
    logic [7:0]  r_erem;
    logic [5:0]  r_scnt;
    logic [1:0]  r_sstate;
    logic [7:0]  r_ssid_mem [SSID_MAX];

    // Table and search.
    logic [47:0]   r_tab [TABLE_DEPTH];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_ptr;
    logic [FW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic [47:0]   r_rd;

    // Summary latch and SSID read pointer.
    logic [2:0]    r_st;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_ch;
    logic [5:0]    r_slen;
    logic [5:0]    r_sptr;
    logic [7:0]    r_sbyte;
    t_out_item     r_out;

    logic [11:0] n_pos;
    logic [5:0]  slen_now;
    logic        hit;
    logic        in_bssid;

    assign in_bssid = (r_pos >= BSSID_FIRST) && (r_pos <= BSSID_LAST);
    assign n_pos    = (r_pos < POS_MAX) ? r_pos + 12'd1 : r_pos;
    assign slen_now = (r_sstate == SS_KEPT) ? r_scnt : 6'd0;
    assign hit      = r_cmp_vld && (r_rd == r_bssid);

    // Byte parser and element walker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pos     <= '0;
            r_type_ok <= 1'b0;
            r_bssid   <= '0;
            r_priv    <= 1'b0;
            r_phase   <= PH_ID;
            r_eid     <= '0;
            r_erem    <= '0;
            r_scnt    <= '0;
            r_sstate  <= SS_NONE;
        end else if (i_cmd.parse) begin
            r_pos <= n_pos;
            if (r_pos == 12'd0) begin
                r_type_ok <= (i_item.data_byte == FC_BEACON) ||
                             (i_item.data_byte == FC_PROBERESP);
            end else if (in_bssid) begin
                r_bssid <= {r_bssid[39:0], i_item.data_byte};
            end else if (r_pos == CAP_POS) begin
                r_priv <= |(i_item.data_byte & CAP_PRIVACY);
            end
            if (r_pos >= IE_START && r_sstate != SS_KEPT) begin
                unique case (r_phase)
                    PH_LEN: begin
                        r_erem <= i_item.data_byte;
                        // An empty SSID element is kept at once.
                        if (r_eid == EID_SSID) begin
                            r_scnt   <= '0;
                            r_sstate <= (i_item.data_byte == 8'd0) ? SS_KEPT : SS_COLL;
                        end
                        if (i_item.data_byte == 8'd0) begin
                            r_phase <= PH_ID;
                        end else begin
                            r_phase <= PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (r_eid == EID_SSID && r_scnt < 6'(SSID_MAX)) begin
                            r_scnt <= r_scnt + 6'd1;
                        end
                        r_erem <= r_erem - 8'd1;
                        if (r_erem == 8'd1) begin
                            if (r_eid == EID_SSID) r_sstate <= SS_KEPT;
                            r_phase <= PH_ID;
                        end
                    end
                    default: begin
                        r_eid   <= i_item.data_byte;
                        r_phase <= PH_LEN;
                    end
                endcase
            end
        end
    end

    // SSID buffer: written while collecting, read one byte per result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.parse && r_pos >= IE_START && r_sstate != SS_KEPT &&
            r_phase == PH_BODY && r_eid == EID_SSID && r_scnt < 6'(SSID_MAX)) begin
            r_ssid_mem[r_scnt[SW-1:0]] <= i_item.data_byte;
        end
        r_sbyte <= r_ssid_mem[r_sptr[SW-1:0]];
    end

    // BSSID table memory with a registered read port, read only on a search step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new) begin
            r_tab[r_fill[AW-1:0]] <= r_bssid;
        end
        if (i_cmd.cmp_step) begin
            r_rd <= r_tab[r_ptr[AW-1:0]];
        end
    end

    // Search pointer, compare stage and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_ptr     <= '0;
            r_cmp_vld <= 1'b0;
            r_cmp_idx <= '0;
        end else begin
            if (i_cmd.cmp_start) begin
                r_ptr     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.cmp_step) begin
                r_cmp_vld <= (r_ptr < r_fill);
                r_cmp_idx <= r_ptr;
                if (r_ptr < r_fill) r_ptr <= r_ptr + FW'(1);
            end
            if (i_cmd.write_new) r_fill <= r_fill + FW'(1);
        end
    end

    // Summary fields, latched once the search outcome is known.
    always_ff @(posedge i_clk) begin
        // The channel belongs to the final byte of the frame.
        if (i_cmd.parse && i_item.frame_last) begin
            r_ch <= i_item.channel;
        end
        if (i_cmd.load_sum) begin
            r_slen <= slen_now;
            r_sptr <= '0;
            if (hit) begin
                r_st  <= ST_KNOWN;
                r_idx <= r_cmp_idx[AW-1:0];
            end else if (r_fill < FW'(TABLE_DEPTH)) begin
                r_st  <= ST_ADDED;
                r_idx <= r_fill[AW-1:0];
            end else begin
                r_st  <= ST_FULL;
                r_idx <= '0;
            end
        end else if (i_cmd.out_load && i_cmd.out_kind == KIND_SSID) begin
            r_sptr <= r_sptr + 6'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.result_kind   <= i_cmd.out_kind;
            r_out.last_result   <= i_cmd.out_last;
            r_out.network_count <= 10'(r_fill);
            r_out.ssid_byte     <= (i_cmd.out_kind == KIND_SSID) ? r_sbyte : 8'd0;
            if (r_pos < MIN_LEN || !r_type_ok) begin
                r_out.status      <= (r_pos < MIN_LEN) ? ST_SHORT : ST_WRONGTYPE;
                r_out.entry_index <= '0;
                r_out.bssid       <= '0;
                r_out.privacy     <= 1'b0;
                r_out.net_channel <= '0;
                r_out.ssid_length <= '0;
            end else begin
                r_out.status      <= r_st;
                r_out.entry_index <= 9'(r_idx);
                r_out.bssid       <= r_bssid;
                r_out.privacy     <= r_priv;
                r_out.net_channel <= r_ch;
                r_out.ssid_length <= r_slen;
            end
        end
    end

    assign o_item            = r_out;
    assign o_sts.short_frame = (r_pos < MIN_LEN);
    assign o_sts.type_bad    = !r_type_ok;
    assign o_sts.scan_done   = !r_cmp_vld && (r_ptr >= r_fill) && !i_cmd.cmp_start;
    assign o_sts.hit         = hit;
    assign o_sts.room        = (r_fill < FW'(TABLE_DEPTH));
    assign o_sts.ssid_zero   = (slen_now == 6'd0);
    assign o_sts.ssid_end    = (r_sptr + 6'd1 == r_slen);

endmodule

[rtl/bbtb_ctrl.sv]
`timescale 1ns / 1ps
module bbtb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  bbtb_pkg::t_in_item i_item,
    input  bbtb_pkg::t_sts  i_sts,
    output bbtb_pkg::t_cmd  o_cmd
);
    import bbtb_pkg::*;

    typedef enum logic [2:0] {
        S_RECV, S_SEARCH, S_DECIDE, S_SUM, S_PREP, S_SSID, S_DONE
    } t_state;

    t_state r_state;
    logic   r_ovalid;
    logic   r_added;
    logic   take, out_free;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_RECV);
    assign take     = i_valid && !o_stall;
    assign o_valid  = r_ovalid;

    // Command decode.
    always_comb begin
        o_cmd = '0;
        o_cmd.parse = take;
        unique case (r_state)
            // The search holds still once a match is seen.
            S_SEARCH: o_cmd.cmp_step = !i_sts.hit;
            S_DECIDE: begin
                o_cmd.load_sum  = 1'b1;
                o_cmd.write_new = !i_sts.hit && i_sts.room;
            end
            S_SUM: begin
                o_cmd.out_load = out_free;
                o_cmd.out_kind = KIND_SUMMARY;
                o_cmd.out_last = !r_added || i_sts.ssid_zero;
            end
            S_SSID: begin
                o_cmd.out_load = out_free;
                o_cmd.out_kind = KIND_SSID;
                o_cmd.out_last = i_sts.ssid_end;
            end
            S_DONE: o_cmd.clear = 1'b1;
            S_RECV: o_cmd.cmp_start = 1'b1;
            default: ;
        endcase
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_RECV;
            r_ovalid <= 1'b0;
            r_added  <= 1'b0;
        end else begin
            r_ovalid <= o_cmd.out_load || (r_ovalid && i_stall);
            unique case (r_state)
                S_RECV: if (take && i_item.frame_last) begin
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (i_sts.short_frame || i_sts.type_bad) begin
                        r_added <= 1'b0;
                        r_state <= S_SUM;
                    end else if (i_sts.hit || i_sts.scan_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_added <= !i_sts.hit && i_sts.room;
                    r_state <= S_SUM;
                end
                S_SUM: if (out_free) begin
                    r_state <= o_cmd.out_last ? S_DONE : S_PREP;
                end
                S_PREP: r_state <= S_SSID;
                S_SSID: if (out_free) begin
                    r_state <= i_sts.ssid_end ? S_DONE : S_PREP;
                end
                S_DONE: r_state <= S_RECV;
                default: r_state <= S_RECV;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RECV) |-> !take) else $error("byte taken while busy");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> out_free) else $error("result overwritten");
    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write_new |=> !o_cmd.write_new) else $error("double table write");
`endif

endmodule

[rtl/beacon_bss_table_builder_core.sv]
`timescale 1ns / 1ps
// Frame bytes are taken one per cycle. After the final byte the block stalls its
// input while it searches the BSSID table linearly, one stored entry per cycle
// through a registered memory read, then emits a summary and, for a new network,
// its SSID bytes as one result each, every byte passing a prepare state before it
// is loaded. No clearing pass is needed after reset: the fill count marks the
// valid entries.
module beacon_bss_table_builder_core #(
    parameter int TABLE_DEPTH = 512,
    parameter int SSID_MAX    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  bbtb_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output bbtb_pkg::t_out_item o_data
);
    import bbtb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bbtb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_item  (i_data),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bbtb_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SSID_MAX    (SSID_MAX)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_item  (o_data)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import bbtb_pkg::*;

    localparam int DEPTH       = 512;
    localparam int SSID_CAP    = 32;
    localparam int CYCLE_LIMIT = 4000000;

    typedef logic [7:0] byte_list_t[$];

    // One directed frame; a negative length means "fit the content".
    typedef struct {
        int          len;
        logic [7:0]  fc;
        logic [47:0] bssid;
        logic [7:0]  cap;
        int          other_len;
        int          ssid_len;
        bit          zero_body;
        logic [7:0]  ch;
        int          typed_status;
    } frame_row_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;

    // Frame parser and BSS table mirror.
    logic [11:0] pos;
    bit          type_ok;
    logic [47:0] cap_bssid;
    bit          cap_priv;
    logic [1:0]  ie_phase;
    logic [7:0]  ie_id;
    logic [7:0]  ie_left;
    logic [7:0]  ssid_buf[SSID_CAP];
    int          ssid_cnt;
    logic [1:0]  ssid_st;
    logic [47:0] known_bssids[DEPTH];
    int          net_fill = 0;

    t_out_item   results_due[$];

    beacon_bss_table_builder_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always #1 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void clear_frame();
        pos      = '0;
        type_ok  = 1'b0;
        cap_bssid = '0;
        cap_priv = 1'b0;
        ie_phase = PH_ID;
        ie_id    = '0;
        ie_left  = '0;
        ssid_cnt = 0;
        ssid_st  = SS_NONE;
    endfunction

    // Walk one information element byte.
    function automatic void walk_element(logic [7:0] b);
        if (ssid_st == SS_KEPT) return;
        if (ie_phase == PH_LEN) begin
            ie_left = b;
            if (ie_id == EID_SSID) begin
                ssid_cnt = 0;
                ssid_st  = SS_COLL;
            end
            if (b == 8'd0) begin
                if (ie_id == EID_SSID) ssid_st = SS_KEPT;
                ie_phase = PH_ID;
            end else begin
                ie_phase = PH_BODY;
            end
        end else if (ie_phase == PH_BODY) begin
            if (ie_id == EID_SSID && ssid_cnt < SSID_CAP) begin
                ssid_buf[ssid_cnt] = b;
                ssid_cnt++;
            end
            ie_left = ie_left - 8'd1;
            if (ie_left == 8'd0) begin
                if (ie_id == EID_SSID) ssid_st = SS_KEPT;
                ie_phase = PH_ID;
            end
        end else begin
            ie_id    = b;
            ie_phase = PH_LEN;
        end
    endfunction

    // Predict the results caused by one accepted frame byte.
    function automatic void predict_byte(t_in_item it);
        t_out_item  r;
        int         slen;
        int         idx;
        bit         found;
        logic [2:0] st;
        if (pos == 12'd0)
            type_ok = (it.data_byte == FC_BEACON || it.data_byte == FC_PROBERESP);
        else if (pos >= BSSID_FIRST && pos <= BSSID_LAST)
            cap_bssid = {cap_bssid[39:0], it.data_byte};
        else if (pos == CAP_POS)
            cap_priv = (it.data_byte & CAP_PRIVACY) != 8'd0;
        if (pos >= IE_START) walk_element(it.data_byte);
        if (pos < POS_MAX) pos = pos + 12'd1;
        if (!it.frame_last) return;

        r = '0;
        r.network_count = net_fill[9:0];
        r.last_result   = 1'b1;
        if (pos < MIN_LEN || !type_ok) begin
            r.status = (pos < MIN_LEN) ? ST_SHORT : ST_WRONGTYPE;
            results_due.push_back(r);
            clear_frame();
            return;
        end
        slen  = (ssid_st == SS_KEPT) ? ssid_cnt : 0;
        found = 1'b0;
        idx   = 0;
        for (int i = 0; i < net_fill; i++) begin
            if (!found && known_bssids[i] == cap_bssid) begin
                found = 1'b1;
                idx   = i;
            end
        end
        if (found) begin
            st = ST_KNOWN;
        end else if (net_fill < DEPTH) begin
            st = ST_ADDED;
            idx = net_fill;
            known_bssids[net_fill] = cap_bssid;
            net_fill++;
        end else begin
            st = ST_FULL;
            idx = 0;
        end
        if (st != ST_ADDED) slen = 0 + slen;
        r.result_kind   = KIND_SUMMARY;
        r.status        = st;
        r.entry_index   = idx[8:0];
        r.bssid         = cap_bssid;
        r.privacy       = cap_priv;
        r.net_channel   = it.channel;
        r.ssid_length   = slen[5:0];
        r.network_count = net_fill[9:0];
        r.last_result   = !(st == ST_ADDED && slen > 0);
        results_due.push_back(r);
        if (st == ST_ADDED) begin
            for (int i = 0; i < slen; i++) begin
                r.result_kind = KIND_SSID;
                r.ssid_byte   = ssid_buf[i];
                r.last_result = (i == slen - 1);
                results_due.push_back(r);
            end
        end
        clear_frame();
    endfunction

    // Lay out a frame: header, optional foreign element, optional SSID, a second SSID.
    function automatic byte_list_t build_frame(frame_row_t row);
        byte_list_t q;
        for (int i = 0; i < 36; i++) q.push_back($urandom_range(0, 255));
        q[0]  = row.fc;
        for (int k = 0; k < 6; k++) q[16 + k] = row.bssid[47 - 8 * k -: 8];
        q[34] = row.cap;
        if (row.other_len >= 0) begin
            q.push_back($urandom_range(1, 255));
            q.push_back(row.other_len[7:0]);
            for (int i = 0; i < row.other_len; i++) q.push_back($urandom_range(0, 255));
        end
        if (row.ssid_len >= 0) begin
            q.push_back(EID_SSID);
            q.push_back(row.ssid_len[7:0]);
            for (int i = 0; i < row.ssid_len; i++)
                q.push_back(row.zero_body ? 8'd0 : 8'($urandom_range(0, 255)));
        end
        q.push_back(EID_SSID);
        q.push_back(8'd3);
        q.push_back(8'h41);
        q.push_back(8'h42);
        q.push_back(8'h43);
        if (row.len < 0) begin
            repeat ($urandom_range(0, 4)) q.push_back($urandom_range(0, 255));
        end else begin
            while (q.size() > row.len) void'(q.pop_back());
            while (q.size() < row.len) q.push_back($urandom_range(0, 255));
        end
        return q;
    endfunction

    // Send one frame byte by byte, with random gaps before each transaction unless calm.
    task automatic send_frame(frame_row_t row);
        byte_list_t q;
        t_in_item   it;
        int         gap;
        q = build_frame(row);
        foreach (q[i]) begin
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            it.data_byte  = q[i];
            it.frame_last = (i == q.size() - 1);
            it.channel    = it.frame_last ? row.ch : 8'($urandom_range(0, 255));
            i_valid <= 1'b1;
            i_data  <= it;
            do @(posedge i_clk); while (o_stall);
            predict_byte(it);
            if (it.frame_last && row.typed_status >= 0) begin
                results_due[$] = '0;
                results_due[$].status        = row.typed_status[2:0];
                results_due[$].network_count = net_fill[9:0];
                results_due[$].last_result   = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    function automatic frame_row_t random_row(logic [47:0] bssid);
        frame_row_t row;
        int sel;
        sel = $urandom_range(0, 19);
        row.fc        = $urandom_range(0, 1) ? FC_BEACON : FC_PROBERESP;
        row.bssid     = bssid;
        row.cap       = $urandom_range(0, 255);
        row.other_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : -1;
        row.ssid_len  = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 40);
        row.zero_body = ($urandom_range(0, 9) == 0);
        row.ch        = $urandom_range(0, 255);
        row.len       = -1;
        row.typed_status = -1;
        if (sel == 0) row.len = $urandom_range(1, 37);
        else if (sel == 1) row.fc = $urandom_range(0, 255);
        else if (sel == 2) row.len = $urandom_range(38, 70);
        return row;
    endfunction

    // The receiver stalls at random before each result, except in calm mode.
    initial begin
        forever begin
            if (!calm) begin
                repeat ($urandom_range(0, 10)) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (results_due.size() == 0) begin
                $error("unexpected result transaction %h", o_data);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                check_field("result_kind", want.result_kind, o_data.result_kind);
                check_field("status", want.status, o_data.status);
                check_field("entry_index", want.entry_index, o_data.entry_index);
                check_field("bssid", want.bssid, o_data.bssid);
                check_field("privacy", want.privacy, o_data.privacy);
                check_field("net_channel", want.net_channel, o_data.net_channel);
                check_field("ssid_length", want.ssid_length, o_data.ssid_length);
                check_field("ssid_byte", want.ssid_byte, o_data.ssid_byte);
                check_field("network_count", want.network_count, o_data.network_count);
                check_field("last_result", want.last_result, o_data.last_result);
            end
        end
    end

    frame_row_t frame_rows[] = '{
        // Too short, single byte and one byte under the minimum.
        '{1,   FC_BEACON,    48'h0,            8'h00, -1, -1, 0, 8'd0,   ST_SHORT},
        '{37,  FC_BEACON,    48'h1,            8'h10, -1, 5,  0, 8'd9,   ST_SHORT},
        // Wrong type, at minimum length and at full length.
        '{38,  8'h00,        48'h2,            8'h10, -1, 4,  0, 8'd1,   ST_WRONGTYPE},
        '{-1,  8'hFF,        48'h3,            8'h00, -1, 8,  0, 8'd255, ST_WRONGTYPE},
        // Minimum length: SSID element cut off, so hidden.
        '{38,  FC_BEACON,    48'h0,            8'hFF, -1, 6,  0, 8'd0,   -1},
        '{-1,  FC_PROBERESP, 48'hFFFFFFFFFFFF, 8'hEF, -1, 32, 0, 8'd255, -1},
        '{-1,  FC_BEACON,    48'h0123456789AB, 8'h10, -1, 40, 0, 8'd6,   -1},
        '{-1,  FC_BEACON,    48'h0123456789AB, 8'h00, -1, 3,  0, 8'd11,  -1},
        '{-1,  FC_BEACON,    48'hA0A0A0A0A0A0, 8'h10, -1, 0,  0, 8'd36,  -1},
        '{-1,  FC_PROBERESP, 48'h5A5A5A5A5A5A, 8'h00, 7,  12, 1, 8'd149, -1},
        '{-1,  FC_BEACON,    48'h00000000AAAA, 8'h10, -1, -1, 0, 8'd3,   -1},
        '{46,  FC_BEACON,    48'h111111111111, 8'h00, -1, 20, 0, 8'd13,  -1},
        '{-1,  FC_BEACON,    48'h222222222222, 8'h10, 255, 5, 0, 8'd44,  -1},
        '{4200, FC_BEACON,   48'h333333333333, 8'h10, -1, 255, 0, 8'd100, -1}
    };

    initial begin
        logic [47:0] pool[8];
        frame_row_t  row;
        clear_frame();
        foreach (ssid_buf[i]) ssid_buf[i] = '0;
        foreach (pool[i]) pool[i] = {$urandom(), 16'($urandom())};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames.
        foreach (frame_rows[i]) send_frame(frame_rows[i]);

        // Random frames, reusing a small BSSID pool so known networks recur.
        for (int f = 0; f < 100; f++) begin
            if (f % 25 == 0) calm = ($urandom_range(0, 2) == 0);
            row = random_row(($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 7)]
                                                          : {$urandom(), 16'($urandom())});
            send_frame(row);
        end
        calm = 1'b0;

        // Fill the table with new networks, then probe a full table.
        while (net_fill < DEPTH) begin
            row = random_row({16'hBEEF, 32'(net_fill)});
            row.len = -1;
            row.fc = FC_BEACON;
            row.ssid_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32) : -1;
            send_frame(row);
        end
        for (int f = 0; f < 12; f++) begin
            row = random_row((f % 2) ? pool[$urandom_range(0, 7)]
                                     : {$urandom(), 16'($urandom())});
            send_frame(row);
        end
        i_valid <= 1'b0;

        while (results_due.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
